@@ sv/hgc_pkg.sv @@
// Shared types and constants for the hash group-count unit.
// No dependencies.
`default_nettype none

package hgc_pkg;

    localparam int TABLE_SLOTS = 4096;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int CFG_W       = 13;
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        OP_AGG  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_COUNTED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO_KEY = 3'd3,
        ST_READ     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic               hit;
        logic               empty;
        logic [COUNT_W-1:0] count_next;
        logic [SLOT_W-1:0]  pos_next;
    } t_eval;

endpackage

`default_nettype wire

@@ sv/hgc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hgc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/hgc_slot_eval.sv @@
// Slot compare unit: key match, empty test, saturating count and wrapped next slot.
// Depends on hgc_pkg.
`default_nettype none

module hgc_slot_eval (
    input  wire hgc_pkg::t_entry                  i_held,
    input  wire logic [hgc_pkg::KEY_W-1:0]        i_key,
    input  wire logic [hgc_pkg::SLOT_W-1:0]       i_pos,
    input  wire logic [hgc_pkg::SIZE_W-1:0]       i_size,
    output hgc_pkg::t_eval                        o_eval
);
    import hgc_pkg::*;

    logic [SIZE_W-1:0] w_pos_inc;

    assign w_pos_inc = {1'b0, i_pos} + SIZE_W'(1);

    always_comb begin
        o_eval.hit        = (i_held.key == i_key);
        o_eval.empty      = (i_held.key == '0);
        o_eval.count_next = (i_held.count == COUNT_MAX) ? COUNT_MAX
                                                        : i_held.count + COUNT_W'(1);
        o_eval.pos_next   = (w_pos_inc >= i_size) ? '0 : w_pos_inc[SLOT_W-1:0];
    end

endmodule

`default_nettype wire

@@ sv/hash_group_count_linear_probe_unit.sv @@
// Top level: group-count aggregation over a linear-probing hash table.
// Depends on hgc_pkg, hgc_ram, hgc_slot_eval.
//
//   channel | signals                                    | dir | handshake
//   --------+--------------------------------------------+-----+----------------------
//   in      | i_op, i_key, i_home_slot, i_read_index     | in  | i_in_valid/o_in_ready
//   out     | o_slot, o_key_out, o_count_out, o_status   | out | o_out_valid/i_out_ready
//   cfg     | i_cfg_wdata (active slots)                 | in  | i_cfg_we, no wait
//
// Table clear after reset: every slot zeroed, one slot a cycle, o_in_ready low meanwhile.
// Read item: S_RD, S_CMP, S_FIN. Zero key: S_FIN only. Aggregate: S_RD then S_CMP for each
// slot probed, the registered read of the single table RAM and one compare per slot, then S_FIN.
// One item in flight; the next is taken while a result waits in the output register.
`default_nettype none

module hash_group_count_linear_probe_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_op,
    input  wire logic [hgc_pkg::KEY_W-1:0]     i_key,
    input  wire logic [hgc_pkg::SLOT_W-1:0]    i_home_slot,
    input  wire logic [hgc_pkg::SLOT_W-1:0]    i_read_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [hgc_pkg::SLOT_W-1:0]         o_slot,
    output logic [hgc_pkg::KEY_W-1:0]          o_key_out,
    output logic [hgc_pkg::COUNT_W-1:0]        o_count_out,
    output logic [2:0]                         o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [hgc_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import hgc_pkg::*;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_active_slots;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [SIZE_W-1:0]   r_visit, n_visit;
    t_op                 r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;

    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [KEY_W-1:0]    r_res_key, n_res_key;
    logic [COUNT_W-1:0]  r_res_count, n_res_count;
    t_status             r_res_status, n_res_status;

    logic                r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [KEY_W-1:0]    r_key_out, n_key_out;
    logic [COUNT_W-1:0]  r_count_out, n_count_out;
    t_status             r_status, n_status;

    logic [SIZE_W-1:0]   w_size;
    logic                ram_we, ram_re;
    logic [SLOT_W-1:0]   ram_waddr;
    t_entry              ram_wdata, ram_rdata;
    t_eval               w_eval;

    // effective table size: zero acts as one, clipped to the table
    always_comb begin
        priority if (r_active_slots == '0) begin
            w_size = SIZE_W'(1);
        end else if (r_active_slots > CFG_W'(TABLE_SLOTS)) begin
            w_size = SIZE_W'(TABLE_SLOTS);
        end else begin
            w_size = SIZE_W'(r_active_slots);
        end
    end

    hgc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    hgc_slot_eval u_eval (
        .i_held (ram_rdata),
        .i_key  (r_key),
        .i_pos  (r_pos),
        .i_size (w_size),
        .o_eval (w_eval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_out_valid    <= 1'b0;
            r_active_slots <= CFG_W'(TABLE_SLOTS);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_active_slots <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_visit      <= n_visit;
        r_op         <= n_op;
        r_key        <= n_key;
        r_res_slot   <= n_res_slot;
        r_res_key    <= n_res_key;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        r_slot       <= n_slot;
        r_key_out    <= n_key_out;
        r_count_out  <= n_count_out;
        r_status     <= n_status;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_pos        = r_pos;
        n_visit      = r_visit;
        n_op         = r_op;
        n_key        = r_key;
        n_res_slot   = r_res_slot;
        n_res_key    = r_res_key;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_slot       = r_slot;
        n_key_out    = r_key_out;
        n_count_out  = r_count_out;
        n_status     = r_status;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_key   = i_key;
                    n_visit = '0;
                    priority if (t_op'(i_op) == OP_READ) begin
                        n_pos   = i_read_index;
                        n_state = S_RD;
                    end else if (i_key == '0) begin
                        n_res_slot   = '0;
                        n_res_key    = '0;
                        n_res_count  = '0;
                        n_res_status = ST_ZERO_KEY;
                        n_state      = S_FIN;
                    end else begin
                        n_pos   = ({1'b0, i_home_slot} < w_size) ? i_home_slot : '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_res_slot = r_pos;
                priority if (r_op == OP_READ) begin
                    n_res_key    = ram_rdata.key;
                    n_res_count  = ram_rdata.count;
                    n_res_status = ST_READ;
                    n_state      = S_FIN;
                end else if (w_eval.hit) begin
                    ram_we          = 1'b1;
                    ram_wdata.key   = r_key;
                    ram_wdata.count = w_eval.count_next;
                    n_res_key       = r_key;
                    n_res_count     = w_eval.count_next;
                    n_res_status    = ST_COUNTED;
                    n_state         = S_FIN;
                end else if (w_eval.empty) begin
                    ram_we          = 1'b1;
                    ram_wdata.key   = r_key;
                    ram_wdata.count = COUNT_W'(1);
                    n_res_key       = r_key;
                    n_res_count     = COUNT_W'(1);
                    n_res_status    = ST_INSERTED;
                    n_state         = S_FIN;
                end else if (r_visit + SIZE_W'(1) == w_size) begin
                    n_res_slot   = '0;
                    n_res_key    = '0;
                    n_res_count  = '0;
                    n_res_status = ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    n_pos   = w_eval.pos_next;
                    n_visit = r_visit + SIZE_W'(1);
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_slot      = r_res_slot;
                    n_key_out   = r_res_key;
                    n_count_out = r_res_count;
                    n_status    = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_slot      = r_slot;
    assign o_key_out   = r_key_out;
    assign o_count_out = r_count_out;
    assign o_status    = r_status;

    a_insert_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == ST_INSERTED) |-> (o_count_out == COUNT_W'(1)
                                                      && o_key_out != '0))
        else $error("inserted item without count of one");

    a_counted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == ST_COUNTED) |-> (o_count_out != '0
                                                     && o_key_out != '0))
        else $error("counted item with empty slot or zero count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_status == ST_FULL || r_status == ST_ZERO_KEY))
        |-> (o_slot == '0 && o_key_out == '0 && o_count_out == '0))
        else $error("rejected item with nonzero payload");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_op == OP_AGG) |-> (r_visit < w_size))
        else $error("probe ran past table size");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_CMP))
        else $error("table written outside clear or compare");

endmodule

`default_nettype wire
